/* rtl/mcns_pkg.sv */
package mcns_pkg;

	// field and register geometry
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_W            = 48;
	localparam int CFG_IDX_W        = 3;
	localparam int COEF_W           = 16;
	localparam int GAIN_W           = 16;
	localparam int NORM_BITS        = 30;
	localparam int SQ_W             = 63;
	localparam int ROOT_W           = 32;
	localparam int QUO_W            = 15;
	localparam int OUT_W            = 16;
	localparam int AVG_W            = 24;
	localparam int SQRT_STEPS       = 32;

	// register reset values
	localparam logic [CFG_W-1:0]  OFFSET_RST = '0;
	localparam logic [CFG_W-1:0]  ROW_X_RST  = 48'd16384;
	localparam logic [CFG_W-1:0]  ROW_Y_RST  = 48'd16384 << 16;
	localparam logic [CFG_W-1:0]  ROW_Z_RST  = 48'd16384 << 32;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd1638;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET = 3'd0,
		REG_ROW_X  = 3'd1,
		REG_ROW_Y  = 3'd2,
		REG_ROW_Z  = 3'd3,
		REG_GAIN   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0]        offset;
		logic [2:0][CFG_W-1:0]   rows;
		logic [GAIN_W-1:0]       gain;
	} mcns_cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MAC,
		OP_ABS,
		OP_NORM,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_DIV_INIT,
		OP_DIV,
		OP_DIV_END,
		OP_EMA_MUL,
		OP_EMA_ADD,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
		logic [1:0] col;
		logic [3:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic big;
	} dp_stat_t;

endpackage

/* rtl/mcns_regs.sv */
module mcns_regs import mcns_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output mcns_cfg_t            cfg
);

	mcns_cfg_t cfg_q;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset  <= OFFSET_RST;
			cfg_q.rows[0] <= ROW_X_RST;
			cfg_q.rows[1] <= ROW_Y_RST;
			cfg_q.rows[2] <= ROW_Z_RST;
			cfg_q.gain    <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET: cfg_q.offset  <= cfg_data;
				REG_ROW_X:  cfg_q.rows[0] <= cfg_data;
				REG_ROW_Y:  cfg_q.rows[1] <= cfg_data;
				REG_ROW_Z:  cfg_q.rows[2] <= cfg_data;
				REG_GAIN:   cfg_q.gain    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/mcns_ctrl.sv */
module mcns_ctrl import mcns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAC, ST_ABS, ST_CHK, ST_NORM, ST_SQ, ST_SQRT_INIT, ST_SQRT,
		ST_DIV_INIT, ST_DIV, ST_DIV_END, ST_EMA_MUL, ST_EMA_ADD, ST_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic [1:0] col_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.idx  = idx_q;
		cmd.col  = col_q;
		cmd.step = cnt_q[3:0];
		unique case (state_q)
			ST_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_MAC:       cmd.op = OP_MAC;
			ST_ABS:       cmd.op = OP_ABS;
			ST_CHK:       cmd.op = OP_NONE;
			ST_NORM:      cmd.op = OP_NORM;
			ST_SQ:        cmd.op = OP_SQ;
			ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			ST_SQRT:      cmd.op = OP_SQRT;
			ST_DIV_INIT:  cmd.op = OP_DIV_INIT;
			ST_DIV:       cmd.op = OP_DIV;
			ST_DIV_END:   cmd.op = OP_DIV_END;
			ST_EMA_MUL:   cmd.op = OP_EMA_MUL;
			ST_EMA_ADD:   cmd.op = OP_EMA_ADD;
			ST_FIN:       cmd.op = out_free ? OP_FIN : OP_NONE;
			default:      cmd.op = OP_NONE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					col_q <= '0;
					if (in_valid)
						state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (col_q == 2'd2) begin
						col_q <= '0;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= ST_ABS;
						end
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				ST_ABS: state_q <= ST_CHK;
				ST_CHK: state_q <= stat.zero ? ST_FIN : ST_NORM;
				ST_NORM: begin
					if (!stat.big)
						state_q <= ST_SQ;
				end
				ST_SQ: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= ST_SQRT_INIT;
					end
				end
				ST_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SQRT_STEPS - 1))
						state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QUO_W - 1))
						state_q <= ST_DIV_END;
				end
				ST_DIV_END: begin
					idx_q   <= idx_q + 2'd1;
					state_q <= ST_DIV_INIT;
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= ST_EMA_MUL;
					end
				end
				ST_EMA_MUL: state_q <= ST_EMA_ADD;
				ST_EMA_ADD: begin
					idx_q   <= idx_q + 2'd1;
					state_q <= ST_EMA_MUL;
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/mcns_dp.sv */
module mcns_dp import mcns_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcns_cfg_t                      cfg,
	input  dp_cmd_t                        cmd,
	output dp_stat_t                       stat,
	input  logic signed [SAMPLE_WIDTH-1:0] raw_x,
	input  logic signed [SAMPLE_WIDTH-1:0] raw_y,
	input  logic signed [SAMPLE_WIDTH-1:0] raw_z,
	output logic signed [OUT_W-1:0]        smooth_out_x,
	output logic signed [OUT_W-1:0]        smooth_out_y,
	output logic signed [OUT_W-1:0]        smooth_out_z,
	output logic                           zero_norm
);

	localparam int DW = ((SAMPLE_WIDTH > COEF_W) ? SAMPLE_WIDTH : COEF_W) + 1;
	localparam int PW = DW + COEF_W;
	localparam int CW = PW + 2;
	localparam int EW = AVG_W + 1;
	localparam int MW = GAIN_W + 1 + EW;

	logic signed [DW-1:0]     d_q   [3];
	logic signed [CW-1:0]     c_q   [3];
	logic        [CW-1:0]     a_q   [3];
	logic        [CW-1:0]     m_q;
	logic        [SQ_W-1:0]   sum_q, n_q, r_q, bit_q;
	logic        [ROOT_W:0]   den_q, rem_q;
	logic        [QUO_W-1:0]  quo_q;
	logic signed [OUT_W-1:0]  u_q   [3];
	logic signed [MW-1:0]     prod_q;
	logic signed [AVG_W-1:0]  avg_q [3];
	logic signed [OUT_W-1:0]  out_q [3];
	logic                     zero_q;

	logic signed [DW-1:0]          raw_ext [3];
	logic signed [COEF_W-1:0]      coef;
	logic signed [PW-1:0]          mac_p;
	logic        [CW-1:0]          a_nx [3];
	logic        [CW-1:0]          m_nx;
	logic [2*NORM_BITS-1:0]        sq_p;
	logic        [SQ_W-1:0]        sq_t;
	logic        [ROOT_W+1:0]      div_sh;
	logic        [QUO_W-1:0]       q_lo;
	logic        [3:0]             q_sel;
	logic                          u_neg;
	logic signed [EW-1:0]          diff;
	logic signed [MW-1:0]          mul_p;
	logic signed [MW-1:0]          inc;
	logic signed [EW-1:0]          rnd [3];

	assign raw_ext[0] = DW'(raw_x);
	assign raw_ext[1] = DW'(raw_y);
	assign raw_ext[2] = DW'(raw_z);

	// soft-iron coefficient pick
	always_comb begin
		unique case (cmd.col)
			2'd0:    coef = cfg.rows[cmd.idx][15:0];
			2'd1:    coef = cfg.rows[cmd.idx][31:16];
			default: coef = cfg.rows[cmd.idx][47:32];
		endcase
	end
	assign mac_p = coef * d_q[cmd.col];

	// magnitudes and their maximum
	always_comb begin
		for (int k = 0; k < 3; k++)
			a_nx[k] = c_q[k][CW-1] ? CW'(-c_q[k]) : CW'(c_q[k]);
		m_nx = a_nx[0];
		if (a_nx[1] > m_nx) m_nx = a_nx[1];
		if (a_nx[2] > m_nx) m_nx = a_nx[2];
	end

	assign stat.zero = (m_q == '0);
	assign stat.big  = |m_q[CW-1:NORM_BITS];

	assign sq_p = a_q[cmd.idx][NORM_BITS-1:0] * a_q[cmd.idx][NORM_BITS-1:0];
	assign sq_t = r_q + bit_q;

	// restoring division, quotient bits of (a*2^15 + q) / 2q
	assign q_lo   = r_q[QUO_W-1:0];
	assign q_sel  = 4'(QUO_W - 1) - cmd.step;
	assign div_sh = {rem_q, q_lo[q_sel]};

	assign u_neg = c_q[cmd.idx][CW-1] ^ (cmd.idx != 2'd0);

	// exponential average
	assign diff  = EW'($signed({u_q[cmd.idx], 8'b0})) - EW'(avg_q[cmd.idx]);
	assign mul_p = $signed({1'b0, cfg.gain}) * diff;
	assign inc   = prod_q + MW'(32768);

	always_comb begin
		for (int k = 0; k < 3; k++)
			rnd[k] = EW'(avg_q[k]) + EW'(128);
	end

	// smoothing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				avg_q[k] <= '0;
		end else if (cmd.op == OP_EMA_ADD) begin
			avg_q[cmd.idx] <= avg_q[cmd.idx] + inc[AVG_W+15:16];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					d_q[k] <= raw_ext[k] - DW'($signed(cfg.offset[16*k +: 16]));
					c_q[k] <= '0;
				end
				sum_q <= '0;
			end
			OP_MAC: c_q[cmd.idx] <= c_q[cmd.idx] + CW'(mac_p);
			OP_ABS: begin
				for (int k = 0; k < 3; k++)
					a_q[k] <= a_nx[k];
				m_q <= m_nx;
			end
			OP_NORM: begin
				if (stat.big) begin
					m_q <= m_q >> 1;
					for (int k = 0; k < 3; k++)
						a_q[k] <= a_q[k] >> 1;
				end
			end
			OP_SQ: sum_q <= sum_q + SQ_W'(sq_p);
			OP_SQRT_INIT: begin
				n_q   <= sum_q;
				r_q   <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 1);
			end
			OP_SQRT: begin
				if (n_q >= sq_t) begin
					n_q <= n_q - sq_t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				den_q <= {r_q[ROOT_W-1:0], 1'b0};
				rem_q <= (ROOT_W+1)'(a_q[cmd.idx][NORM_BITS-1:0])
					+ (ROOT_W+1)'(r_q[ROOT_W-1:QUO_W]);
				quo_q <= '0;
			end
			OP_DIV: begin
				if (div_sh >= (ROOT_W+2)'(den_q)) begin
					rem_q <= (ROOT_W+1)'(div_sh - (ROOT_W+2)'(den_q));
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[ROOT_W:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			OP_DIV_END: u_q[cmd.idx] <= u_neg ? -$signed({1'b0, quo_q})
				: $signed({1'b0, quo_q});
			OP_EMA_MUL: prod_q <= mul_p;
			OP_FIN: begin
				for (int k = 0; k < 3; k++)
					out_q[k] <= rnd[k][AVG_W-1:8];
				zero_q <= stat.zero;
			end
			default: ;
		endcase
	end

	assign smooth_out_x = out_q[0];
	assign smooth_out_y = out_q[1];
	assign smooth_out_z = out_q[2];
	assign zero_norm    = zero_q;

endmodule

/* rtl/magnetometer_calibrate_normalize_smooth_unit.sv */
// Magnetometer calibration: each accepted sample has the hard-iron offset
// removed, goes through the 3x3 soft-iron matrix, is scaled to unit length
// (Q1.14, y and z negated) and feeds a per-axis exponential average whose
// rounded value comes out with a zero-length flag in tuser. One sample is
// worked on at a time: a multiply-accumulate sequence (9 MAC steps), a
// bit-per-cycle normalize shift (up to 3 steps), a 32-step square root and
// three 15-step restoring divisions; the next sample can be taken in the
// cycle after the result is written. A finished result waits in the output
// register while the next sample is taken. A zero-length sample skips the
// normalize, square root and divisions and leaves the average untouched.
module magnetometer_calibrate_normalize_smooth_unit import mcns_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int IN_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_W-1:0]      s_axis_tdata,  // raw_x, raw_y, raw_z, zero pad
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [3*OUT_W-1:0]   m_axis_tdata,  // smooth_out_x, smooth_out_y, smooth_out_z
	output logic                 m_axis_tuser   // zero_norm
);

	mcns_cfg_t cfg;
	dp_cmd_t   cmd;
	dp_stat_t  stat;
	logic signed [OUT_W-1:0] sx, sy, sz;

	mcns_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcns_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.raw_x        (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.raw_y        (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.raw_z        (s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
		.smooth_out_x (sx),
		.smooth_out_y (sy),
		.smooth_out_z (sz),
		.zero_norm    (m_axis_tuser)
	);

	assign m_axis_tdata = {sz, sy, sx};

	// one sample in flight: accepting closes the input until done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a sample is in work");

	// a result is written only into a free output slot
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwrote a pending transaction");

	// a load happens only with an accepted transaction
	a_load_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (s_axis_tvalid && s_axis_tready))
		else $error("sample loaded without a transaction");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import mcns_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

	typedef struct {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
		logic             zero_norm;
	} heading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;  // raw_x, raw_y, raw_z
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [3*OUT_W-1:0]   m_axis_tdata;  // smooth_out_x, smooth_out_y, smooth_out_z
	logic                 m_axis_tuser;  // zero_norm

	magnetometer_calibrate_normalize_smooth_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// shadow calibration registers and smoothing state
	logic [CFG_W-1:0]  cal_offset;
	logic [CFG_W-1:0]  cal_row [3];
	logic [GAIN_W-1:0] cal_gain;
	int                avg [3];

	logic [47:0] sample_q [$];
	heading_t    heading_q [$];
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_len;
	bit  sample_taken;
	int  idle_cycles;
	int  errors;
	int  n_results;
	int  n_zero;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// calibrate, normalize, negate y/z, update the averages
	function automatic heading_t predict_heading(input logic [47:0] raw);
		longint d [3];
		longint c [3];
		longint unsigned a [3];
		longint unsigned m;
		longint unsigned sum;
		longint unsigned q;
		longint unsigned r;
		longint u [3];
		longint diff;
		longint prod;
		int s;
		heading_t h;
		m = 0;
		sum = 0;
		s = 0;
		for (int i = 0; i < 3; i++)
			d[i] = longint'($signed(raw[16*i +: 16])) - longint'($signed(cal_offset[16*i +: 16]));
		for (int i = 0; i < 3; i++) begin
			c[i] = 0;
			for (int j = 0; j < 3; j++)
				c[i] += longint'($signed(cal_row[i][16*j +: 16])) * d[j];
			a[i] = (c[i] < 0) ? -c[i] : c[i];
			if (a[i] > m)
				m = a[i];
		end
		h.zero_norm = (m == 0);
		if (m != 0) begin
			while ((m >> s) >= (64'd1 << NORM_BITS))
				s++;
			for (int i = 0; i < 3; i++) begin
				a[i] = a[i] >> s;
				sum += a[i] * a[i];
			end
			q = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				r = (a[i] * 32768 + q) / (2 * q);
				u[i] = (c[i] < 0) ? -longint'(r) : longint'(r);
			end
			u[1] = -u[1];
			u[2] = -u[2];
			for (int i = 0; i < 3; i++) begin
				diff = u[i] * 256 - longint'(avg[i]);
				prod = longint'({48'd0, cal_gain}) * diff;
				avg[i] = int'(longint'(avg[i]) + ((prod + 32768) >>> 16));
			end
		end
		h.x = 16'((longint'(avg[0]) + 128) >>> 8);
		h.y = 16'((longint'(avg[1]) + 128) >>> 8);
		h.z = 16'((longint'(avg[2]) + 128) >>> 8);
		return h;
	endfunction

	// acceptance, prediction, result check, watchdog
	always @(posedge clk) begin
		heading_t want;
		if (arst_n) begin
			idle_cycles = idle_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				idle_cycles = 0;
				n_results = n_results + 1;
				if (heading_q.size() == 0) begin
					$error("result with no sample outstanding");
					errors = errors + 1;
				end else begin
					want = heading_q.pop_front();
					if (m_axis_tdata[15:0] !== want.x) begin
						$error("smooth_out_x exp %h got %h", want.x, m_axis_tdata[15:0]);
						errors = errors + 1;
					end
					if (m_axis_tdata[31:16] !== want.y) begin
						$error("smooth_out_y exp %h got %h", want.y, m_axis_tdata[31:16]);
						errors = errors + 1;
					end
					if (m_axis_tdata[47:32] !== want.z) begin
						$error("smooth_out_z exp %h got %h", want.z, m_axis_tdata[47:32]);
						errors = errors + 1;
					end
					if (m_axis_tuser !== want.zero_norm) begin
						$error("zero_norm exp %b got %b", want.zero_norm, m_axis_tuser);
						errors = errors + 1;
					end
					if (want.zero_norm)
						n_zero = n_zero + 1;
				end
			end
			sample_taken = s_axis_tvalid && s_axis_tready;
			if (sample_taken) begin
				idle_cycles = 0;
				heading_q.push_back(predict_heading(s_axis_tdata));
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || sample_taken)) begin
			if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_OFFSET: cal_offset = val;
			REG_ROW_X:  cal_row[0] = val;
			REG_ROW_Y:  cal_row[1] = val;
			REG_ROW_Z:  cal_row[2] = val;
			REG_GAIN:   cal_gain = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] rx,
			input logic [CFG_W-1:0] ry, input logic [CFG_W-1:0] rz, input logic [GAIN_W-1:0] g);
		write_reg(REG_OFFSET, off);
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_GAIN, {32'd0, g});
	endtask

	// wait until every sample is through and the block is quiet
	task automatic drain();
		while (sample_q.size() > 0 || s_axis_tvalid || heading_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_row(input int axis);
		logic [CFG_W-1:0] row;
		if ($urandom_range(1)) begin
			row = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
		end else begin
			row = '0;
			for (int j = 0; j < 3; j++)
				row[16*j +: 16] = (j == axis) ? 16'(16384 + $urandom_range(4000) - 2000)
					: 16'($urandom_range(3000) - 1500);
		end
		return row;
	endfunction

	task automatic push_random(input int count);
		logic [47:0] raw;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0: raw = cal_offset;
				1, 2: begin
					for (int i = 0; i < 3; i++)
						raw[16*i +: 16] = cal_offset[16*i +: 16] + 16'($urandom_range(6) - 3);
				end
				default: raw = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
			endcase
			sample_q.push_back(raw);
		end
	endtask

	task automatic random_setup();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(5))
			0: g = '0;
			1: g = 16'hFFFF;
			default: g = 16'($urandom);
		endcase
		write_all({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, rand_row(0), rand_row(1),
			rand_row(2), g);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cal_offset = OFFSET_RST;
		cal_row[0] = ROW_X_RST;
		cal_row[1] = ROW_Y_RST;
		cal_row[2] = ROW_Z_RST;
		cal_gain = GAIN_RST;
		avg = '{0, 0, 0};
		sample_q = {};
		heading_q = {};
		send_idle_pct = 13;
		recv_idle_pct = 74;
		hold_len = 0;
		sample_taken = 0;
		idle_cycles = 0;
		errors = 0;
		n_results = 0;
		n_zero = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset calibration, zero vector, field extremes
		sample_q.push_back(48'h0);
		sample_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
		sample_q.push_back({16'h8000, 16'h8000, 16'h8000});
		sample_q.push_back({16'h8000, 16'h0000, 16'h7FFF});
		sample_q.push_back({16'h0001, 16'hFFFF, 16'h0000});
		sample_q.push_back(48'h0);
		drain();
		// extreme offsets and coefficients, full gain
		write_all({16'h8000, 16'h7FFF, 16'h8000}, {3{16'h8000}}, {3{16'h7FFF}},
			{16'h7FFF, 16'h8000, 16'h7FFF}, 16'hFFFF);
		sample_q.push_back({16'h7FFF, 16'h8000, 16'h7FFF});
		sample_q.push_back({16'h8000, 16'h7FFF, 16'h8000});
		sample_q.push_back({16'h8000, 16'h7FFF, 16'h8000});
		sample_q.push_back(48'h0);
		drain();
		// gain zero holds the averages; unmapped index must not disturb anything
		write_reg(REG_GAIN, '0);
		write_reg(REG_UNMAPPED, {3{16'h1234}});
		sample_q.push_back({16'h0100, 16'hFE00, 16'h0300});
		sample_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
		drain();
		// all-zero matrix: every sample has zero length
		write_all('0, '0, '0, '0, 16'd30000);
		sample_q.push_back({16'h1111, 16'h2222, 16'h3333});
		sample_q.push_back({16'h8000, 16'h7FFF, 16'h0001});
		drain();
		write_all(OFFSET_RST, ROW_X_RST, ROW_Y_RST, ROW_Z_RST, GAIN_RST);

		// phase one: sender mostly busy, receiver mostly stalled, one long hold-off
		push_random(120);
		repeat (50) @(posedge clk);
		hold_len = 600;
		drain();
		random_setup();
		push_random(110);
		drain();

		// phase two: roles swapped
		send_idle_pct = 74;
		recv_idle_pct = 13;
		random_setup();
		push_random(120);
		drain();
		random_setup();
		push_random(110);
		drain();

		// phase three: full rate, with a pause of the sender until all results are in
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_setup();
		push_random(60);
		drain();
		push_random(60);
		drain();
		random_setup();
		push_random(120);
		drain();
		repeat (200) @(posedge clk);

		$display("Checked %0d smoothed headings (%0d zero-length) over several calibration",
			n_results, n_zero);
		$display("sets, gain extremes and three handshake idle profiles.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/mcns_pkg.sv
rtl/mcns_regs.sv
rtl/mcns_ctrl.sv
rtl/mcns_dp.sv
rtl/magnetometer_calibrate_normalize_smooth_unit.sv
tb/tb.sv
